### hdl/pdkg_pkg.sv
// Shared constants, register codes and controller/datapath structs for the
// pose distance keyframe gate. No dependencies.
package pdkg_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam int POS_W  = 24;
    localparam int HEAD_W = 20;
    localparam int MEM_W  = 2 * POS_W + HEAD_W;
    localparam int DIST_W = 50;

    localparam int THR_W = 24;
    localparam int WGT_W = 8;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT    = 2'd1;

    localparam logic [THR_W-1:0]  THR_RESET = 24'd1311;
    localparam logic [WGT_W-1:0]  WGT_RESET = 8'd10;
    localparam logic [DIST_W-1:0] DIST_MAX  = {DIST_W{1'b1}};

    typedef struct packed {
        logic load;
        logic issue;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic scan_done;
        logic pipe_busy;
    } t_stat;

endpackage

### hdl/pdkg_if.sv
// Valid/ready channel interfaces for pose requests, results and configuration.
// Depends on pdkg_pkg.
interface pdkg_pose_if;
    logic                                valid;
    logic                                ready;
    logic signed [pdkg_pkg::POS_W-1:0]   pose_x;
    logic signed [pdkg_pkg::POS_W-1:0]   pose_y;
    logic signed [pdkg_pkg::HEAD_W-1:0]  pose_heading;

    modport source (output valid, pose_x, pose_y, pose_heading, input ready);
    modport sink   (input valid, pose_x, pose_y, pose_heading, output ready);
endinterface

interface pdkg_result_if;
    logic                               valid;
    logic                               ready;
    logic                               saved;
    logic [pdkg_pkg::ADDR_W-1:0]        entry_index;
    logic [pdkg_pkg::DIST_W-1:0]        nearest_distance_sq;
    logic                               table_full;
    logic [pdkg_pkg::CNT_W-1:0]         entry_total;

    modport source (output valid, saved, entry_index, nearest_distance_sq, table_full,
                    entry_total, input ready);
    modport sink   (input valid, saved, entry_index, nearest_distance_sq, table_full,
                    entry_total, output ready);
endinterface

interface pdkg_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [pdkg_pkg::CFG_IDX_W-1:0]     index;
    logic [pdkg_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### hdl/pdkg_ctrl.sv
// Sequencing state machine: accepts a request, scans the table, drains the
// distance pipeline and commits the result. Depends on pdkg_pkg.
module pdkg_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    input  pdkg_pkg::t_stat  i_stat,
    output pdkg_pkg::t_cmd   o_cmd
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_DRAIN  = 4'b0100,
        ST_FINISH = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (i_stat.scan_done) begin
                    n_state = ST_DRAIN;
                end else begin
                    o_cmd.issue = 1'b1;
                end
            end
            ST_DRAIN: begin
                if (!i_stat.pipe_busy) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.commit = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.commit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    a_commit_shows_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |=> (r_out_valid && r_state == ST_IDLE))
        else $error("commit did not present a result");

    a_finish_after_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FINISH) |-> !i_stat.pipe_busy)
        else $error("finish reached with distance pipeline still busy");

endmodule

### hdl/pdkg_dp.sv
// Datapath: configuration registers, keyframe memory, distance pipeline,
// running minimum and result registers. Depends on pdkg_pkg.
module pdkg_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  pdkg_pkg::t_cmd                      i_cmd,
    output pdkg_pkg::t_stat                     o_stat,
    input  logic                                i_cfg_we,
    input  logic [pdkg_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [pdkg_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic [pdkg_pkg::POS_W-1:0]          i_pose_x,
    input  logic [pdkg_pkg::POS_W-1:0]          i_pose_y,
    input  logic [pdkg_pkg::HEAD_W-1:0]         i_pose_heading,
    output logic                                o_saved,
    output logic [pdkg_pkg::ADDR_W-1:0]         o_entry_index,
    output logic [pdkg_pkg::DIST_W-1:0]         o_nearest_distance_sq,
    output logic                                o_table_full,
    output logic [pdkg_pkg::CNT_W-1:0]          o_entry_total
);

    localparam int PD_W  = pdkg_pkg::POS_W + 1;
    localparam int HD_W  = pdkg_pkg::HEAD_W + 1;
    localparam int PSQ_W = 2 * PD_W;
    localparam int HSQ_W = 2 * HD_W;
    localparam int WH_W  = HSQ_W + pdkg_pkg::WGT_W;
    localparam int SXY_W = PSQ_W + 1;
    localparam int SUM_W = ((SXY_W > WH_W) ? SXY_W : WH_W) + 1;
    localparam int TSQ_W = 2 * pdkg_pkg::THR_W;

    logic [pdkg_pkg::THR_W-1:0]  r_threshold;
    logic [pdkg_pkg::WGT_W-1:0]  r_weight;
    logic [TSQ_W-1:0]            r_thr_sq;

    logic [pdkg_pkg::MEM_W-1:0]  mem [pdkg_pkg::TABLE_DEPTH];
    logic [pdkg_pkg::MEM_W-1:0]  r_rd;

    logic [pdkg_pkg::POS_W-1:0]  r_px;
    logic [pdkg_pkg::POS_W-1:0]  r_py;
    logic [pdkg_pkg::HEAD_W-1:0] r_ph;

    logic [pdkg_pkg::CNT_W-1:0]  r_count;
    logic [pdkg_pkg::CNT_W-1:0]  r_scan_idx;
    logic                        r_v0, r_v1, r_v2, r_v3, r_v4;

    logic [PD_W-1:0]   dx, dy, adx, ady;
    logic [HD_W-1:0]   dh, adh;
    logic [PD_W-1:0]   r_adx, r_ady;
    logic [HD_W-1:0]   r_adh;
    logic [PSQ_W-1:0]  r_sqx, r_sqy;
    logic [HSQ_W-1:0]  r_sqh;
    logic [SXY_W-1:0]  r_sxy;
    logic [WH_W-1:0]   r_wh;
    logic [SUM_W-1:0]  sum;
    logic [pdkg_pkg::DIST_W-1:0] sat_sum;
    logic [pdkg_pkg::DIST_W-1:0] r_dist;
    logic [pdkg_pkg::DIST_W-1:0] r_best;

    logic [pdkg_pkg::POS_W-1:0]  sx, sy;
    logic [pdkg_pkg::HEAD_W-1:0] sh;
    logic                        want, room, do_save;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= pdkg_pkg::THR_RESET;
            r_weight    <= pdkg_pkg::WGT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                pdkg_pkg::REG_THRESHOLD: r_threshold <= i_cfg_data[pdkg_pkg::THR_W-1:0];
                pdkg_pkg::REG_WEIGHT:    r_weight    <= i_cfg_data[pdkg_pkg::WGT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_thr_sq <= r_threshold * r_threshold;
    end

    assign want    = (r_count == '0) || (r_best > pdkg_pkg::DIST_W'(r_thr_sq));
    assign room    = r_count < pdkg_pkg::CNT_W'(pdkg_pkg::TABLE_DEPTH);
    assign do_save = want && room;

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && do_save) begin
            mem[r_count[pdkg_pkg::ADDR_W-1:0]] <= {r_px, r_py, r_ph};
        end
        if (i_cmd.issue) begin
            r_rd <= mem[r_scan_idx[pdkg_pkg::ADDR_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_scan_idx <= '0;
            r_v0       <= 1'b0;
            r_v1       <= 1'b0;
            r_v2       <= 1'b0;
            r_v3       <= 1'b0;
            r_v4       <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_scan_idx <= '0;
            end else if (i_cmd.issue) begin
                r_scan_idx <= r_scan_idx + 1'b1;
            end
            if (i_cmd.commit && do_save) begin
                r_count <= r_count + 1'b1;
            end
            r_v0 <= i_cmd.issue;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    assign o_stat.scan_done = (r_scan_idx == r_count);
    assign o_stat.pipe_busy = r_v0 | r_v1 | r_v2 | r_v3 | r_v4;

    assign {sx, sy, sh} = r_rd;
    assign dx  = {r_px[pdkg_pkg::POS_W-1], r_px} - {sx[pdkg_pkg::POS_W-1], sx};
    assign dy  = {r_py[pdkg_pkg::POS_W-1], r_py} - {sy[pdkg_pkg::POS_W-1], sy};
    assign dh  = {r_ph[pdkg_pkg::HEAD_W-1], r_ph} - {sh[pdkg_pkg::HEAD_W-1], sh};
    assign adx = dx[PD_W-1] ? (~dx + 1'b1) : dx;
    assign ady = dy[PD_W-1] ? (~dy + 1'b1) : dy;
    assign adh = dh[HD_W-1] ? (~dh + 1'b1) : dh;

    assign sum     = SUM_W'(r_sxy) + SUM_W'(r_wh);
    assign sat_sum = (sum[SUM_W-1:pdkg_pkg::DIST_W] != '0) ? pdkg_pkg::DIST_MAX
                                                          : sum[pdkg_pkg::DIST_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_px <= i_pose_x;
            r_py <= i_pose_y;
            r_ph <= i_pose_heading;
        end
        r_adx  <= adx;
        r_ady  <= ady;
        r_adh  <= adh;
        r_sqx  <= r_adx * r_adx;
        r_sqy  <= r_ady * r_ady;
        r_sqh  <= r_adh * r_adh;
        r_sxy  <= SXY_W'(r_sqx) + SXY_W'(r_sqy);
        r_wh   <= r_sqh * r_weight;
        r_dist <= sat_sum;
        if (i_cmd.load) begin
            r_best <= pdkg_pkg::DIST_MAX;
        end else if (r_v4 && (r_dist < r_best)) begin
            r_best <= r_dist;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            o_saved               <= do_save;
            o_entry_index         <= do_save ? r_count[pdkg_pkg::ADDR_W-1:0] : '0;
            o_nearest_distance_sq <= r_best;
            o_table_full          <= want && !room;
            o_entry_total         <= do_save ? (r_count + 1'b1) : r_count;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= pdkg_pkg::CNT_W'(pdkg_pkg::TABLE_DEPTH))
        else $error("keyframe count above table depth");

    a_best_falls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v4 && !i_cmd.load) |=> (r_best <= $past(r_best)))
        else $error("running minimum increased during scan");

    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.issue && i_cmd.commit))
        else $error("table read and write in the same cycle");

endmodule

### hdl/pose_distance_keyframe_gate.sv
// Top level of the pose distance keyframe gate: controller plus datapath.
// Depends on pdkg_pkg, pdkg_if, pdkg_ctrl and pdkg_dp.
//
//   Channel    Direction  Payload
//   i_pose     in         pose_x, pose_y, pose_heading
//   o_result   out        saved, entry_index, nearest_distance_sq, table_full, entry_total
//   i_cfg      in         index, data (0: distance_threshold, 1: heading_weight)
//
// A request is accepted only once the previous one has committed. It is compared with every stored
// entry; with an empty table no entry is read. The table is read one entry a cycle through the
// single read port, then a five stage distance pipeline drains. A finished result waits in the
// output register while the next request is accepted and scanned; that request stalls before
// commit until the previous result is taken. Reset is synchronous and clears the table count;
// the configuration port is always ready.
module pose_distance_keyframe_gate (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    pdkg_pose_if.sink              i_pose,
    pdkg_result_if.source          o_result,
    pdkg_cfg_if.sink               i_cfg
);

    pdkg_pkg::t_cmd  cmd;
    pdkg_pkg::t_stat stat;

    assign i_cfg.ready = 1'b1;

    pdkg_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_pose.valid),
        .o_in_ready  (i_pose.ready),
        .o_out_valid (o_result.valid),
        .i_out_ready (o_result.ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    pdkg_dp u_dp (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_cmd                 (cmd),
        .o_stat                (stat),
        .i_cfg_we              (i_cfg.valid),
        .i_cfg_index           (i_cfg.index),
        .i_cfg_data            (i_cfg.data),
        .i_pose_x              (i_pose.pose_x),
        .i_pose_y              (i_pose.pose_y),
        .i_pose_heading        (i_pose.pose_heading),
        .o_saved               (o_result.saved),
        .o_entry_index         (o_result.entry_index),
        .o_nearest_distance_sq (o_result.nearest_distance_sq),
        .o_table_full          (o_result.table_full),
        .o_entry_total         (o_result.entry_total)
    );

endmodule
